### rtl/sha_pkg.sv
// SHA-256 shared types, constants and round functions.
package sha_pkg;

    localparam logic [31:0] C_INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] C_ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] C_PAD_BYTE = 8'h80;
    localparam logic       C_KIND_DATA   = 1'b0;
    localparam logic       C_KIND_FINISH = 1'b1;

    typedef logic [31:0] t_word;
    typedef t_word t_vars [8];

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // round control from sequencer to compression core
    typedef struct packed {
        logic       start;   // load working vars from hash
        logic       round;   // perform one round with w
        logic       fold;    // add working vars into hash
        logic       restore; // reload initial hash
        logic [5:0] t;
    } t_round_ctl;

endpackage

### rtl/sha_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/sha_core.sv
// SHA-256 round datapath: hash words, working variables, one round a cycle while round is set.
module sha_core
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_round_ctl i_ctl,
    input  t_word      i_w,
    output t_vars      o_hash
);
    t_vars r_h, r_v;
    t_word big1, ch, t1, big0, maj;

    always_comb begin
        big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + big1 + ch + C_ROUND_K[i_ctl.t] + i_w;
        big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= C_INIT_H;
        end else if (i_ctl.restore) begin
            r_h <= C_INIT_H;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
        if (i_ctl.start) begin
            r_v <= r_h;
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + big0 + maj;
        end
    end

    assign o_hash = r_h;
endmodule

### rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level: block RAM, sequencer, digest output.
//
//  Channel | Dir | tdata fields (low bit up)        | tuser
//  s_axis  | in  | data_byte[7:0]                   | kind
//  m_axis  | out | digest_word[31:0], word_index[34:32] | tlast = last_word
//
// Data beats are taken one a cycle while idle; the 64th byte of a block starts
// a compression that holds input off: rounds 0..15 each first read four bytes
// from the block RAM (one port, one read a cycle, plus the registered read),
// then rounds 16..63 take words from the schedule window and a fold step adds
// the working variables into the hash. A finish beat writes padding (one byte a
// cycle) and runs one or two compressions, then presents eight words, one per
// cycle when the sink is ready. Reset is synchronous, active low; the block RAM
// holds no reset. An output stall freezes the sequencer with the current word held.
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero
    output logic        m_axis_tlast    // last_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_FETCH, S_ROUND, S_FOLD, S_OUT
    } t_state;

    t_state      r_state;
    logic [60:0] r_count;
    logic [5:0]  r_pos;      // write pointer within block
    logic [5:0]  r_t;        // round number
    logic [1:0]  r_b;        // byte within word during fetch
    logic [2:0]  r_rd_ph;    // fetch phase 0..4 (registered RAM read)
    logic        r_final;    // compression belongs to a finish
    logic        r_second;   // finish needs another block after this one
    logic [2:0]  r_widx;
    logic [63:0] r_bits;
    t_word       r_wacc;
    t_word       r_wwin [16];
    t_round_ctl  ctl;
    t_vars       hash;

    logic        we;
    logic [5:0]  waddr, raddr;
    logic [7:0]  wdata, rdata;
    t_word       w_new, w_cur;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    sha_core u_core (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_w(w_cur),
        .o_hash(hash));

    assign s_axis_tready = (r_state == S_IDLE);
    wire in_fire = s_axis_tvalid && s_axis_tready;

    // byte write: data beats, padding zeros/0x80, length bytes
    always_comb begin
        we = 1'b0; waddr = r_pos; wdata = s_axis_tdata;
        case (r_state)
            S_IDLE: begin
                we = in_fire;
                wdata = (s_axis_tuser == C_KIND_FINISH) ? C_PAD_BYTE : s_axis_tdata;
            end
            S_PAD: begin we = 1'b1; wdata = 8'h00; end
            S_LEN: begin we = 1'b1; wdata = r_bits[63 - 8*r_pos[2:0] -: 8]; end
            default: we = 1'b0;
        endcase
        raddr = {r_t[3:0], r_b};
    end

    // rounds 0..15 take bytes from RAM, later words from the schedule window
    assign w_new = sig1(r_wwin[14]) + r_wwin[9] + sig0(r_wwin[1]) + r_wwin[0];
    assign w_cur = (r_t < 6'd16) ? r_wacc : w_new;

    always_comb begin
        ctl = '0;
        ctl.t = r_t;
        ctl.round = (r_state == S_ROUND);
        ctl.fold = (r_state == S_FOLD);
        ctl.restore = (r_state == S_OUT) && m_axis_tready && (r_widx == 3'd7);
        ctl.start = (r_state == S_FETCH) && (r_t == 6'd0) && (r_rd_ph == 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_pos <= '0; r_t <= '0;
            r_b <= '0; r_rd_ph <= '0; r_final <= 1'b0; r_second <= 1'b0;
            r_widx <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (in_fire) begin
                    r_pos <= r_pos + 6'd1;
                    r_t <= '0; r_b <= '0; r_rd_ph <= '0;
                    if (s_axis_tuser == C_KIND_DATA) begin
                        r_count <= r_count + 61'd1;
                        r_final <= 1'b0;
                        if (r_pos == 6'd63) r_state <= S_FETCH;
                    end else begin
                        r_bits <= {r_count, 3'b000};
                        r_final <= 1'b1;
                        r_second <= (r_pos >= 6'd56);
                        if (r_pos == 6'd63) r_state <= S_FETCH;
                        else if (r_pos == 6'd55) r_state <= S_LEN;
                        else r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= S_FETCH;
                    else if (r_pos == 6'd55 && !r_second) r_state <= S_LEN;
                end
                S_LEN: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= S_FETCH;
                end
                S_FETCH: begin
                    // 4 reads, then a last phase that captures the final byte
                    if (r_rd_ph != 3'd0) r_wacc <= {r_wacc[23:0], rdata};
                    r_b <= r_b + 2'd1;
                    r_rd_ph <= r_rd_ph + 3'd1;
                    if (r_rd_ph == 3'd4) begin
                        r_rd_ph <= '0; r_b <= '0; r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_wwin[i] <= r_wwin[i+1];
                    r_wwin[15] <= w_cur;
                    r_t <= r_t + 6'd1;
                    if (r_t == 6'd63) r_state <= S_FOLD;
                    else if (r_t < 6'd15) r_state <= S_FETCH;
                end
                S_FOLD: begin
                    r_t <= '0;
                    if (!r_final) r_state <= S_IDLE;
                    else if (r_second) begin
                        r_second <= 1'b0; r_state <= S_PAD;
                    end else begin
                        r_widx <= '0; r_state <= S_OUT;
                    end
                end
                S_OUT: if (m_axis_tready) begin
                    r_widx <= r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        r_state <= S_IDLE; r_count <= '0; r_pos <= '0;
                        r_final <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_widx, hash[r_widx]};
    assign m_axis_tlast  = (r_widx == 3'd7);

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_out_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("output overlaps input");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (r_state == S_IDLE)
        && (r_count == 61'd0)) else $error("no restore after digest");
endmodule
